// ----- hdl/ultrasonic_link_frame_receiver_defines.svh -----
// Assertion macros for the ultrasonic link frame receiver.
// No dependencies; included by the port checker.
`ifndef ULTRASONIC_LINK_FRAME_RECEIVER_DEFINES_SVH
`define ULTRASONIC_LINK_FRAME_RECEIVER_DEFINES_SVH

// check outside reset
`define ULFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check through reset
`define ULFR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/ulfr_pkg.sv -----
// Shared types and constants for the ultrasonic link frame receiver.
// No dependencies; used by every design module of the block.
package ulfr_pkg;

    localparam logic [1:0] MODE_RX   = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_CMD  = 2'd2;

    localparam logic [7:0] TYPE_DIST  = 8'h02;
    localparam logic [7:0] TYPE_REPLY = 8'h03;

    localparam logic [7:0] HOLD_TICKS_RESET = 8'd100;

    localparam logic [2:0] POS_TYPE      = 3'd1;
    localparam logic [2:0] POS_REPLY_END = 3'd2;
    localparam logic [2:0] POS_DIST_HI   = 3'd3;
    localparam logic [2:0] FRAME_LEN     = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic       rx_error;
        logic [2:0] cmd_code;
        logic       cmd_write;
        logic [3:0] cmd_arg;
    } t_item;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

// ----- hdl/ulfr_in_reg.sv -----
// Input register stage of the ultrasonic link frame receiver.
// Depends on ulfr_pkg.
module ulfr_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ulfr_pkg::t_item     i_item,
    input  logic                i_advance,
    output logic                o_in_stall,
    output ulfr_pkg::t_stage_ctl o_ctl,
    output ulfr_pkg::t_item     o_item
);

    logic            r_valid;
    logic            n_valid;
    ulfr_pkg::t_item r_item;
    logic            w_load;

    assign w_load     = !r_valid || i_advance;
    assign o_in_stall = !w_load;
    assign n_valid    = w_load ? i_in_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_item <= i_item;
        end
    end

    assign o_ctl.valid   = r_valid;
    assign o_ctl.advance = i_advance;
    assign o_item        = r_item;

endmodule

// ----- hdl/ulfr_core.sv -----
// Frame decode, tick and command logic with the result register.
// Depends on ulfr_pkg.
module ulfr_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ulfr_pkg::t_stage_ctl i_ctl,
    input  ulfr_pkg::t_item      i_item,
    input  logic [7:0]           i_hold_ticks,
    input  logic                 i_out_stall,
    output logic                 o_advance,
    output logic                 o_out_valid,
    output logic                 o_tx_valid,
    output logic [7:0]           o_tx_byte,
    output logic [13:0]          o_distance,
    output logic                 o_distance_valid,
    output logic                 o_reply_pending
);

    logic        r_out_valid;
    logic [2:0]  r_pos;
    logic [2:0]  n_pos;
    logic [7:0]  r_type;
    logic [7:0]  n_type;
    logic [6:0]  r_dist_hi;
    logic [6:0]  n_dist_hi;
    logic [13:0] r_dist;
    logic [13:0] n_dist;
    logic        r_dvalid;
    logic        n_dvalid;
    logic [7:0]  r_hold;
    logic [7:0]  n_hold;
    logic        r_reply;
    logic        n_reply;
    logic        r_tx_valid;
    logic        n_tx_valid;
    logic [7:0]  r_tx_byte;
    logic [7:0]  n_tx_byte;
    logic        w_fire;
    logic [2:0]  w_pos_next;
    logic [7:0]  w_type_now;

    assign o_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = i_ctl.valid && i_ctl.advance;
    assign w_pos_next = r_pos + 3'd1;
    assign w_type_now = (w_pos_next == ulfr_pkg::POS_TYPE) ? i_item.rx_byte : r_type;

    always_comb begin
        n_pos      = r_pos;
        n_type     = r_type;
        n_dist_hi  = r_dist_hi;
        n_dist     = r_dist;
        n_dvalid   = r_dvalid;
        n_hold     = r_hold;
        n_reply    = r_reply;
        n_tx_valid = 1'b0;
        n_tx_byte  = 8'd0;
        case (i_item.mode)
            ulfr_pkg::MODE_RX: begin
                if (!i_item.rx_error) begin
                    if (i_item.rx_byte == 8'd0) begin
                        n_pos = 3'd0;
                    end else begin
                        n_pos = w_pos_next;
                        if (w_pos_next == ulfr_pkg::POS_TYPE) begin
                            n_type = i_item.rx_byte;
                        end
                        if (w_pos_next == ulfr_pkg::POS_DIST_HI) begin
                            n_dist_hi = i_item.rx_byte[6:0];
                        end
                        if (w_type_now == ulfr_pkg::TYPE_DIST &&
                            w_pos_next >= ulfr_pkg::FRAME_LEN) begin
                            n_dist   = {r_dist_hi, i_item.rx_byte[6:0]};
                            n_dvalid = 1'b1;
                            n_hold   = i_hold_ticks;
                            n_pos    = 3'd0;
                        end else if (w_type_now == ulfr_pkg::TYPE_REPLY &&
                                     w_pos_next >= ulfr_pkg::POS_REPLY_END) begin
                            n_reply = 1'b0;
                            n_pos   = 3'd0;
                        end else if (w_pos_next > ulfr_pkg::FRAME_LEN) begin
                            n_pos = 3'd0;
                        end
                    end
                end
            end
            ulfr_pkg::MODE_TICK: begin
                if (r_hold != 8'd0) begin
                    n_hold = r_hold - 8'd1;
                end else begin
                    n_dvalid = 1'b0;
                end
            end
            ulfr_pkg::MODE_CMD: begin
                n_tx_valid = 1'b1;
                n_tx_byte  = {i_item.cmd_arg, i_item.cmd_write, i_item.cmd_code};
                n_reply    = 1'b1;
            end
            default: begin
                n_tx_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= 3'd0;
            r_dist      <= 14'd0;
            r_dvalid    <= 1'b0;
            r_hold      <= 8'd0;
            r_reply     <= 1'b0;
        end else begin
            if (o_advance) begin
                r_out_valid <= i_ctl.valid;
            end
            if (w_fire) begin
                r_pos    <= n_pos;
                r_dist   <= n_dist;
                r_dvalid <= n_dvalid;
                r_hold   <= n_hold;
                r_reply  <= n_reply;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_type     <= n_type;
            r_dist_hi  <= n_dist_hi;
            r_tx_valid <= n_tx_valid;
            r_tx_byte  <= n_tx_byte;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tx_valid       = r_tx_valid;
    assign o_tx_byte        = r_tx_byte;
    assign o_distance       = r_dist;
    assign o_distance_valid = r_dvalid;
    assign o_reply_pending  = r_reply;

endmodule

// ----- hdl/ultrasonic_link_frame_receiver.sv -----
// Top level of the ultrasonic link frame receiver.
// Depends on ulfr_pkg, ulfr_in_reg and ulfr_core.
//
//   channel   valid        stall        payload
//   input     i_in_valid   o_in_stall   i_mode, i_rx_byte, i_rx_error, i_cmd_*
//   output    o_out_valid  i_out_stall  o_tx_*, o_distance*, o_reply_pending
//   config    i_cfg_we     -            i_cfg_data
//
// One transaction per cycle while the output is not stalled; a result passes through
// the input register, then the decode logic into the result register.
// Synchronous active-low reset clears the frame position, distance and hold counter and
// the valid, distance-valid and reply flags; hold ticks reset to 100.
// A stalled output holds the result and fills the input register, then stalls the input.
module ultrasonic_link_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_error,
    input  logic [2:0]  i_cmd_code,
    input  logic        i_cmd_write,
    input  logic [3:0]  i_cmd_arg,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic [13:0] o_distance,
    output logic        o_distance_valid,
    output logic        o_reply_pending
);

    logic [7:0]           r_hold_ticks;
    ulfr_pkg::t_item      w_item_in;
    ulfr_pkg::t_item      w_item;
    ulfr_pkg::t_stage_ctl w_ctl;
    logic                 w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= ulfr_pkg::HOLD_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_hold_ticks <= i_cfg_data;
        end
    end

    assign w_item_in.mode      = i_mode;
    assign w_item_in.rx_byte   = i_rx_byte;
    assign w_item_in.rx_error  = i_rx_error;
    assign w_item_in.cmd_code  = i_cmd_code;
    assign w_item_in.cmd_write = i_cmd_write;
    assign w_item_in.cmd_arg   = i_cmd_arg;

    ulfr_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (w_item_in),
        .i_advance  (w_advance),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl),
        .o_item     (w_item)
    );

    ulfr_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .i_item           (w_item),
        .i_hold_ticks     (r_hold_ticks),
        .i_out_stall      (i_out_stall),
        .o_advance        (w_advance),
        .o_out_valid      (o_out_valid),
        .o_tx_valid       (o_tx_valid),
        .o_tx_byte        (o_tx_byte),
        .o_distance       (o_distance),
        .o_distance_valid (o_distance_valid),
        .o_reply_pending  (o_reply_pending)
    );

endmodule

// ----- hdl/ulfr_port_checker.sv -----
// Port-level checks for the ultrasonic link frame receiver, bound to the top level.
// Depends on ultrasonic_link_frame_receiver_defines.svh.
`include "ultrasonic_link_frame_receiver_defines.svh"

module ulfr_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_tx_valid,
    input logic [7:0]  o_tx_byte,
    input logic [13:0] o_distance,
    input logic        o_distance_valid,
    input logic        o_reply_pending
);

    `ULFR_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tx_byte) && $stable(o_distance) && $stable(o_reply_pending), "stalled transaction changed")
    `ULFR_ASSERT(a_tx_zero, o_out_valid && !o_tx_valid |-> o_tx_byte == 8'd0, "tx byte set without tx valid")
    `ULFR_ASSERT(a_cmd_reply, o_out_valid && o_tx_valid |-> o_reply_pending, "command sent without reply pending")
    `ULFR_ASSERT(a_dvalid_rise, $rose(o_distance_valid) |-> o_out_valid, "distance valid rose without a transaction")
    `ULFR_ASSERT_RST(a_reset_clear, !i_rst_n |=> !o_out_valid && !o_distance_valid && !o_reply_pending, "state not cleared by reset")

endmodule

bind ultrasonic_link_frame_receiver ulfr_port_checker u_port_checker (.*);
